### hdl/hid_keyboard_report_to_key_events_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the keyboard report to key event converter
// Immediate-cycle and next-cycle implication checks on the module clock.
// ---------------------------------------------------------------------------
`ifndef HID_KEYBOARD_REPORT_TO_KEY_EVENTS_MACROS_SVH
`define HID_KEYBOARD_REPORT_TO_KEY_EVENTS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HIDKRE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HIDKRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/hidkre_pkg.sv
// ---------------------------------------------------------------------------
// Keyboard report to key event package
// Payload types, event codes and the keypad mapping used by the converter modules.
// ---------------------------------------------------------------------------
package hidkre_pkg;

    // Report geometry and keycode rules.
    localparam int SLOT_COUNT      = 6;
    localparam int DIGIT_COUNT     = 10;
    localparam int KEYCODE_LIMIT   = 256;
    localparam int KEYPAD_ONE_CODE = 89;
    localparam int MAIN_ONE_CODE   = 30;
    localparam logic [7:0] REBOOT_MASK_RESET = 8'd69;

    // Event kinds.
    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_RESET   = 2'd2;

    typedef logic [7:0] t_code;
    typedef logic [SLOT_COUNT-1:0][7:0] t_code_vec;
    typedef logic [SLOT_COUNT-1:0] t_slot_mask;

    // One incoming boot-keyboard report.
    typedef struct packed {
        logic [7:0] modifiers;
        logic [7:0] key_slot_0;
        logic [7:0] key_slot_1;
        logic [7:0] key_slot_2;
        logic [7:0] key_slot_3;
        logic [7:0] key_slot_4;
        logic [7:0] key_slot_5;
    } t_report;

    // One outgoing key event.
    typedef struct packed {
        logic [1:0] event_kind;
        logic [7:0] keycode;
        logic [7:0] event_modifiers;
        logic       last_event;
    } t_event;

    // Findings of one lane.
    typedef struct packed {
        logic press;
        logic release_key;
        logic keep;
    } t_lane_flags;

    // Next event chosen by the merging stage.
    typedef struct packed {
        logic       any;
        logic       is_release;
        t_slot_mask sel;
        t_code      code;
        logic       last;
    } t_pick;

    // Keypad digits are renamed to the main-row digits.
    function automatic t_code map_key(input t_code k);
        t_code diff;
        diff = k - 8'(KEYPAD_ONE_CODE);
        if ({1'b0, k} >= 9'(KEYPAD_ONE_CODE) &&
            {1'b0, k} < 9'(KEYPAD_ONE_CODE + DIGIT_COUNT)) begin
            return diff + 8'(MAIN_ONE_CODE);
        end
        return k;
    endfunction

    // A mapped key counts when it is nonzero and below the keycode limit.
    function automatic logic key_usable(input t_code k);
        return (k != 8'd0) && ({1'b0, k} < 9'(KEYCODE_LIMIT));
    endfunction

endpackage

### hdl/hidkre_lane.sv
// ---------------------------------------------------------------------------
// Keyboard report lane
// Compares one slot of the new report and one entry of the held-key list
// against the other side, giving its press, release and keep flags.
// ---------------------------------------------------------------------------
module hidkre_lane #(
    parameter int LANE_IDX = 0
) (
    input  hidkre_pkg::t_code_vec   i_cur_code,
    input  hidkre_pkg::t_slot_mask  i_cur_vld,
    input  hidkre_pkg::t_code_vec   i_prev_code,
    input  hidkre_pkg::t_slot_mask  i_prev_vld,
    output hidkre_pkg::t_lane_flags o_flags
);
    import hidkre_pkg::*;

    logic dup;
    logic was_down;
    logic still_held;

    // Match this lane's slot against earlier slots and the held list, and its held entry against the report.
    always_comb begin
        dup        = 1'b0;
        was_down   = 1'b0;
        still_held = 1'b0;
        for (int j = 0; j < SLOT_COUNT; j++) begin
            if (j < LANE_IDX && i_cur_vld[j] && i_cur_code[j] == i_cur_code[LANE_IDX]) begin
                dup = 1'b1;
            end
            if (i_prev_vld[j] && i_prev_code[j] == i_cur_code[LANE_IDX]) begin
                was_down = 1'b1;
            end
            if (i_cur_vld[j] && i_cur_code[j] == i_prev_code[LANE_IDX]) begin
                still_held = 1'b1;
            end
        end
    end

    // A repeated key only counts in its first slot.
    assign o_flags.keep        = i_cur_vld[LANE_IDX] && !dup;
    assign o_flags.press       = i_cur_vld[LANE_IDX] && !dup && !was_down;
    assign o_flags.release_key = i_prev_vld[LANE_IDX] && !still_held;

endmodule

### hdl/hidkre_merge.sv
// ---------------------------------------------------------------------------
// Keyboard event merging stage
// Picks the next event from the pending lane flags: presses in slot order
// first, then releases in ascending keycode order.
// ---------------------------------------------------------------------------
module hidkre_merge (
    input  hidkre_pkg::t_slot_mask i_press,
    input  hidkre_pkg::t_slot_mask i_release,
    input  hidkre_pkg::t_code_vec  i_cur_code,
    input  hidkre_pkg::t_code_vec  i_prev_code,
    output hidkre_pkg::t_pick      o_pick
);
    import hidkre_pkg::*;

    t_slot_mask press_sel;
    t_slot_mask release_sel;
    t_code      press_code;
    t_code      release_code;
    logic       found;

    // Lowest pending press slot.
    always_comb begin
        press_sel  = '0;
        press_code = '0;
        found      = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (i_press[i] && !found) begin
                press_sel[i] = 1'b1;
                press_code   = i_cur_code[i];
                found        = 1'b1;
            end
        end
    end

    // Smallest pending release code; held codes are unique, so one wins.
    always_comb begin
        release_sel  = i_release;
        release_code = '0;
        for (int j = 0; j < SLOT_COUNT; j++) begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
                if (k != j && i_release[k] && i_prev_code[k] < i_prev_code[j]) begin
                    release_sel[j] = 1'b0;
                end
            end
        end
        for (int j = 0; j < SLOT_COUNT; j++) begin
            if (release_sel[j]) begin
                release_code = i_prev_code[j];
            end
        end
    end

    // Presses go before releases; last when nothing else is pending.
    always_comb begin
        o_pick.any = (i_press != '0) || (i_release != '0);
        if (i_press != '0) begin
            o_pick.is_release = 1'b0;
            o_pick.sel        = press_sel;
            o_pick.code       = press_code;
            o_pick.last       = ((i_press & ~press_sel) == '0) && (i_release == '0);
        end else begin
            o_pick.is_release = 1'b1;
            o_pick.sel        = release_sel;
            o_pick.code       = release_code;
            o_pick.last       = (i_release & ~release_sel) == '0;
        end
    end

endmodule

### hdl/hid_keyboard_report_to_key_events.sv
// The first event of a report is offered once the report is captured, its lane findings
// are registered and the event is loaded into the output register. One report at a time:
// a new report is accepted only while idle; a report gives 0 to 12 events (a reset request
// gives 1), and the sink can stall the events.
// Events leave through the single output register, one a cycle while the sink is ready.
// Reset clears the held-key list, the pending flags and the output valid, and loads the
// reboot mask with 69; the block is ready in the first cycle after reset.
// ---------------------------------------------------------------------------
// Keyboard report to key events
// Converts boot-keyboard reports into press, release and reset-request events
// using six comparison lanes and a merging stage.
// ---------------------------------------------------------------------------
`include "hid_keyboard_report_to_key_events_macros.svh"

module hid_keyboard_report_to_key_events (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hidkre_pkg::t_report i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hidkre_pkg::t_event  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data
);
    import hidkre_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [7:0]  r_mask, n_mask;
    logic [7:0]  r_mods, n_mods;
    logic        r_reboot, n_reboot;
    t_code_vec   r_cur_code, n_cur_code;
    t_slot_mask  r_cur_vld, n_cur_vld;
    t_code_vec   r_down_code, n_down_code;
    t_slot_mask  r_down_vld, n_down_vld;
    t_slot_mask  r_press, n_press;
    t_slot_mask  r_release, n_release;
    t_slot_mask  r_keep, n_keep;
    logic        r_out_vld, n_out_vld;
    t_event      r_out, n_out;

    t_code_vec   in_slots;
    t_lane_flags lane_flags [SLOT_COUNT];
    t_pick       pick;
    logic        can_load;

    assign in_slots = {i_in_data.key_slot_5, i_in_data.key_slot_4, i_in_data.key_slot_3,
                       i_in_data.key_slot_2, i_in_data.key_slot_1, i_in_data.key_slot_0};

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign can_load    = !r_out_vld || i_out_ready;

    // One lane per key slot and held-key entry.
    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_lane
        hidkre_lane #(
            .LANE_IDX (g)
        ) u_lane (
            .i_cur_code  (r_cur_code),
            .i_cur_vld   (r_cur_vld),
            .i_prev_code (r_down_code),
            .i_prev_vld  (r_down_vld),
            .o_flags     (lane_flags[g])
        );
    end

    // Merging stage picks the next event to send.
    hidkre_merge u_merge (
        .i_press     (r_press),
        .i_release   (r_release),
        .i_cur_code  (r_cur_code),
        .i_prev_code (r_down_code),
        .o_pick      (pick)
    );

    // Sequencer and output register.
    always_comb begin
        n_state     = r_state;
        n_mask      = r_mask;
        n_mods      = r_mods;
        n_reboot    = r_reboot;
        n_cur_code  = r_cur_code;
        n_cur_vld   = r_cur_vld;
        n_down_code = r_down_code;
        n_down_vld  = r_down_vld;
        n_press     = r_press;
        n_release   = r_release;
        n_keep      = r_keep;
        n_out       = r_out;
        n_out_vld   = r_out_vld && !i_out_ready;

        if (i_cfg_valid) begin
            n_mask = i_cfg_data;
        end

        case (r_state)
            ST_IDLE: begin
                // Capture the report with keypad digits already renamed.
                if (i_in_valid) begin
                    n_mods   = i_in_data.modifiers;
                    n_reboot = (i_in_data.modifiers & r_mask) == r_mask;
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        n_cur_code[i] = map_key(in_slots[i]);
                        n_cur_vld[i]  = key_usable(map_key(in_slots[i]));
                    end
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                // Register the lane findings; a reset request changes no keys.
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    n_press[i]   = lane_flags[i].press && !r_reboot;
                    n_release[i] = lane_flags[i].release_key && !r_reboot;
                    n_keep[i]    = lane_flags[i].keep;
                end
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (r_reboot) begin
                    if (can_load) begin
                        n_out_vld             = 1'b1;
                        n_out.event_kind      = KIND_RESET;
                        n_out.keycode         = '0;
                        n_out.event_modifiers = '0;
                        n_out.last_event      = 1'b1;
                        n_state               = ST_IDLE;
                    end
                end else if (!pick.any) begin
                    // Nothing changed: just take over the new key list.
                    n_down_code = r_cur_code;
                    n_down_vld  = r_keep;
                    n_state     = ST_IDLE;
                end else if (can_load) begin
                    n_out_vld             = 1'b1;
                    n_out.event_kind      = pick.is_release ? KIND_RELEASE : KIND_PRESS;
                    n_out.keycode         = pick.code;
                    n_out.event_modifiers = pick.is_release ? 8'd0 : r_mods;
                    n_out.last_event      = pick.last;
                    if (pick.is_release) begin
                        n_release = r_release & ~pick.sel;
                    end else begin
                        n_press = r_press & ~pick.sel;
                    end
                    if (pick.last) begin
                        n_down_code = r_cur_code;
                        n_down_vld  = r_keep;
                        n_state     = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_mask     <= REBOOT_MASK_RESET;
            r_down_vld <= '0;
            r_press    <= '0;
            r_release  <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_mask     <= n_mask;
            r_down_vld <= n_down_vld;
            r_press    <= n_press;
            r_release  <= n_release;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_mods      <= n_mods;
        r_reboot    <= n_reboot;
        r_cur_code  <= n_cur_code;
        r_cur_vld   <= n_cur_vld;
        r_down_code <= n_down_code;
        r_keep      <= n_keep;
        r_out       <= n_out;
    end

    // Checks on the event sequencing.
    `HIDKRE_ASSERT_NOW(a_pick_onehot, r_state == ST_EMIT && !r_reboot, $onehot0(pick.sel), "merging stage selected more than one lane")
    `HIDKRE_ASSERT_NOW(a_reset_event_form, r_out_vld && r_out.event_kind == KIND_RESET, r_out.last_event && r_out.keycode == 8'd0 && r_out.event_modifiers == 8'd0, "malformed reset request event")
    `HIDKRE_ASSERT_NOW(a_idle_no_pending, r_state == ST_IDLE, r_press == '0 && r_release == '0, "events still pending while idle")
    `HIDKRE_ASSERT_NOW(a_press_nonzero, r_out_vld && r_out.event_kind == KIND_PRESS, r_out.keycode != 8'd0, "press event with empty keycode")
    `HIDKRE_ASSERT_NEXT(a_last_ends_report, r_state == ST_EMIT && n_out_vld && n_out.last_event && !(r_out_vld && !i_out_ready), r_state == ST_IDLE, "report not finished after its last event")

endmodule
